[sv/tbfe_pkg.sv]
// Shared types and byte constants for the telnet byte filter and escaper.
package tbfe_pkg;

	localparam logic [7:0] BYTE_IAC    = 8'd255;
	localparam logic [7:0] BYTE_SE     = 8'd240;
	localparam logic [7:0] BYTE_SB     = 8'd250;
	localparam logic [7:0] BYTE_CMD_LO = 8'd241;
	localparam logic [7:0] BYTE_CMD_HI = 8'd249;
	localparam logic [7:0] BYTE_OPT_LO = 8'd251;
	localparam logic [7:0] BYTE_OPT_HI = 8'd254;
	localparam logic [7:0] BYTE_CR     = 8'd13;
	localparam logic [7:0] BYTE_NUL    = 8'd0;

	localparam logic OP_RX = 1'b0;
	localparam logic OP_TX = 1'b1;

	localparam logic DIR_HOST = 1'b0;
	localparam logic DIR_LINK = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic       direction;
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_START = 5'b00001,
		ST_IAC   = 5'b00010,
		ST_CMD   = 5'b00100,
		ST_SUB1  = 5'b01000,
		ST_SUB2  = 5'b10000
	} parse_state_t;

endpackage

[sv/telnet_byte_filter_and_escaper.sv]
// Top level: input register, IAC filter / TX escaper, two-entry result buffer.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------
//  in      | in_valid / in_ready  | in_data  (opcode, data_byte)
//  out     | out_valid / out_ready| out_data (direction, out_byte, last)
//
// One request per cycle; a receive byte yields 0 or 1 results, a transmit
// byte 1 or 2. Results drain one per cycle from a two-entry buffer, so a run
// of 0xFF or CR transmits is paced by the output port. Input to first result
// passes the input register, then the result buffer. Reset puts the parser
// in its start state, clears the CR flag and empties both stages. A stalled
// output holds the buffer and backs up into in_ready.
module telnet_byte_filter_and_escaper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tbfe_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output tbfe_pkg::out_item_t out_data
);
	import tbfe_pkg::*;

	localparam logic [2:0] BUF_DEPTH = 3'd2;

	logic      valid_s1;
	in_item_t  item_s1;

	out_item_t buf_q [2];
	logic      wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	logic      rx_deliver;
	logic      rx_step;
	logic      consume;
	logic      pop;
	logic [1:0] n_res;
	logic [2:0] n_free;
	out_item_t r0, r1;

	// result generation from the registered request
	always_comb begin
		r0 = '{direction: DIR_LINK, out_byte: item_s1.data_byte, last: 1'b1};
		r1 = '{direction: DIR_LINK, out_byte: item_s1.data_byte, last: 1'b1};
		n_res = 2'd0;
		if (item_s1.opcode == OP_TX) begin
			if (item_s1.data_byte == BYTE_IAC) begin
				r0.last = 1'b0;
				n_res   = 2'd2;
			end else if (item_s1.data_byte == BYTE_CR) begin
				r0.last     = 1'b0;
				r1.out_byte = BYTE_NUL;
				n_res       = 2'd2;
			end else begin
				n_res = 2'd1;
			end
		end else begin
			r0.direction = DIR_HOST;
			n_res        = rx_deliver ? 2'd1 : 2'd0;
		end
	end

	assign pop      = out_valid && out_ready;
	assign n_free   = BUF_DEPTH - {1'b0, cnt_q} + {2'b00, pop};
	assign consume  = valid_s1 && ({1'b0, n_res} <= n_free);
	assign rx_step  = consume && item_s1.opcode == OP_RX;
	assign in_ready = !valid_s1 || consume;

	tbfe_rx_parser u_rx_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (rx_step),
		.rx_byte (item_s1.data_byte),
		.deliver (rx_deliver)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (consume) begin
				wr_ptr_q <= wr_ptr_q ^ n_res[0];
			end
			rd_ptr_q <= rd_ptr_q ^ pop;
			cnt_q    <= cnt_q + (consume ? n_res : 2'd0) - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (consume && n_res != 2'd0) begin
			buf_q[wr_ptr_q] <= r0;
		end
		if (consume && n_res == 2'd2) begin
			buf_q[~wr_ptr_q] <= r1;
		end
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = buf_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("result buffer overfilled");

	a_tx_yields: assert property (@(posedge clk) disable iff (!arst_n)
		consume && item_s1.opcode == OP_TX |=> out_valid)
		else $error("transmit request produced no result");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !consume |=> valid_s1 && $stable(item_s1))
		else $error("stalled request lost");

endmodule

[sv/tbfe_rx_parser.sv]
// Receive-side IAC parser with CR NUL suppression.
module tbfe_rx_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output logic       deliver
);
	import tbfe_pkg::*;

	parse_state_t state_q, state_d;
	logic         last_was_cr_q;
	logic         clear_cr;

	always_comb begin
		state_d  = ST_START;
		deliver  = 1'b0;
		clear_cr = 1'b0;
		case (state_q)
			ST_IAC: begin
				if (rx_byte inside {[BYTE_CMD_LO:BYTE_CMD_HI]}) begin
					state_d = ST_START;
				end else if (rx_byte == BYTE_SB) begin
					state_d = ST_SUB1;
				end else if (rx_byte inside {[BYTE_OPT_LO:BYTE_OPT_HI]}) begin
					state_d = ST_CMD;
				end else begin
					deliver = 1'b1;
				end
			end
			ST_CMD: begin
				state_d = ST_START;
			end
			ST_SUB1: begin
				state_d = (rx_byte == BYTE_IAC) ? ST_SUB2 : ST_SUB1;
			end
			ST_SUB2: begin
				state_d = (rx_byte == BYTE_SE) ? ST_START : ST_SUB1;
			end
			default: begin
				if (rx_byte == BYTE_IAC) begin
					state_d = ST_IAC;
				end else if (last_was_cr_q && rx_byte == BYTE_NUL) begin
					clear_cr = 1'b1;
				end else begin
					deliver = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_START;
			last_was_cr_q <= 1'b0;
		end else if (step) begin
			state_q <= state_d;
			if (deliver) begin
				last_was_cr_q <= (rx_byte == BYTE_CR);
			end else if (clear_cr) begin
				last_was_cr_q <= 1'b0;
			end
		end
	end

	a_cmd_drops_one: assert property (@(posedge clk) disable iff (!arst_n)
		step && state_q == ST_CMD |=> state_q == ST_START)
		else $error("option byte not consumed after WILL/WONT/DO/DONT");

	a_no_deliver_in_sub: assert property (@(posedge clk) disable iff (!arst_n)
		deliver |-> !(state_q == ST_CMD || state_q == ST_SUB1 || state_q == ST_SUB2))
		else $error("delivery while inside negotiation");

	a_cr_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		step && deliver && rx_byte == BYTE_CR |=> last_was_cr_q)
		else $error("delivered CR not remembered");

endmodule

[tb/tb.sv]
// Self-checking testbench for the telnet byte filter and escaper.
`timescale 1ns / 100ps

module tb;
	import tbfe_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1000000;
	localparam int unsigned RANDOM_ITEMS  = 1480;
	localparam int unsigned DRAIN_CYCLES  = 8;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	// predictor state
	parse_state_t rx_state;
	logic         cr_seen;
	out_item_t    expected_results[$];

	int unsigned errors;
	int unsigned requests_sent;
	int unsigned requests_accepted;
	int unsigned results_seen;
	int unsigned cycles;

	// receiver controls
	int unsigned hold_cnt;
	int unsigned stall_left;
	bit          no_idle;

	telnet_byte_filter_and_escaper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_rx_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return BYTE_CR;
		if (r < 30)
			return BYTE_NUL;
		return 8'($urandom_range(0, 254));
	endfunction

	function automatic logic [7:0] pick_tx_char();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return BYTE_IAC;
		if (r < 35)
			return BYTE_CR;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void push_result(logic dir, logic [7:0] b, logic fin);
		out_item_t r;
		r.direction = dir;
		r.out_byte  = b;
		r.last      = fin;
		expected_results.push_back(r);
	endfunction

	// Expected output of the filter/escaper for one accepted request.
	function automatic void predict_filter(in_item_t req);
		logic [7:0] b;
		logic       deliver;
		b       = req.data_byte;
		deliver = 1'b0;
		if (req.opcode == OP_TX) begin
			if (b == BYTE_IAC) begin
				push_result(DIR_LINK, BYTE_IAC, 1'b0);
				push_result(DIR_LINK, BYTE_IAC, 1'b1);
			end else if (b == BYTE_CR) begin
				push_result(DIR_LINK, BYTE_CR, 1'b0);
				push_result(DIR_LINK, BYTE_NUL, 1'b1);
			end else begin
				push_result(DIR_LINK, b, 1'b1);
			end
			return;
		end
		case (rx_state)
			ST_IAC: begin
				if (b >= BYTE_CMD_LO && b <= BYTE_CMD_HI) begin
					rx_state = ST_START;
				end else if (b == BYTE_SB) begin
					rx_state = ST_SUB1;
				end else if (b >= BYTE_OPT_LO && b <= BYTE_OPT_HI) begin
					rx_state = ST_CMD;
				end else begin
					rx_state = ST_START;
					deliver  = 1'b1;
				end
			end
			ST_CMD: rx_state = ST_START;
			ST_SUB1: rx_state = (b == BYTE_IAC) ? ST_SUB2 : ST_SUB1;
			ST_SUB2: rx_state = (b == BYTE_SE) ? ST_START : ST_SUB1;
			default: begin
				rx_state = ST_START;
				if (b == BYTE_IAC) begin
					rx_state = ST_IAC;
				end else if (cr_seen && b == BYTE_NUL) begin
					cr_seen = 1'b0;
				end else begin
					deliver = 1'b1;
				end
			end
		endcase
		if (deliver) begin
			cr_seen = (b == BYTE_CR);
			push_result(DIR_HOST, b, 1'b1);
		end
	endfunction

	// Offer one request after a random gap and hold it until accepted.
	task automatic send_request(input logic op, input logic [7:0] b);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{opcode: op, data_byte: b};
		do @(posedge clk); while (!(in_ready === 1'b1));
		requests_sent++;
	endtask

	task automatic test_tx_escaping();
		send_request(OP_TX, 8'h00);
		send_request(OP_TX, BYTE_IAC);
		send_request(OP_TX, BYTE_CR);
		send_request(OP_TX, 8'h80);
	endtask

	task automatic test_iac_commands();
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, BYTE_CMD_HI);
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, BYTE_IAC);   // escaped 0xFF delivered
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, BYTE_SE);    // SE outside SB is just data
	endtask

	task automatic test_option_negotiation();
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, BYTE_OPT_LO);
		send_request(OP_RX, 8'h01);
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, BYTE_OPT_HI);
		send_request(OP_RX, BYTE_IAC);   // option byte swallowed even if 0xFF
	endtask

	task automatic test_subnegotiation();
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, BYTE_SB);
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, 8'h07);      // IAC not followed by SE stays inside
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, BYTE_SE);
	endtask

	task automatic test_cr_nul();
		send_request(OP_RX, BYTE_CR);
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, BYTE_CMD_LO); // dropped command keeps CR flag
		send_request(OP_RX, BYTE_NUL);    // dropped
		send_request(OP_RX, BYTE_NUL);    // second NUL delivered
		send_request(OP_RX, BYTE_IAC);
		send_request(OP_RX, BYTE_CR);     // CR delivered through IAC
		send_request(OP_RX, BYTE_NUL);    // dropped
	endtask

	// Mostly well-formed Telnet traffic with random content, some noise.
	task automatic test_random_traffic(input int unsigned count);
		int unsigned stop_at;
		int unsigned kind;
		int unsigned len;
		int unsigned k;
		logic [7:0]  b;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				send_request(OP_RX, pick_rx_char());
			end else if (kind < 35) begin
				send_request(OP_RX, BYTE_CR);
				send_request(OP_RX, BYTE_NUL);
				if ($urandom_range(0, 2) == 0)
					send_request(OP_RX, BYTE_NUL);
			end else if (kind < 45) begin
				send_request(OP_RX, BYTE_IAC);
				send_request(OP_RX, 8'($urandom_range(BYTE_CMD_LO, BYTE_CMD_HI)));
			end else if (kind < 57) begin
				send_request(OP_RX, BYTE_IAC);
				send_request(OP_RX, 8'($urandom_range(BYTE_OPT_LO, BYTE_OPT_HI)));
				send_request(OP_RX, 8'($urandom_range(0, 255)));
			end else if (kind < 67) begin
				send_request(OP_RX, BYTE_IAC);
				send_request(OP_RX, BYTE_SB);
				len = $urandom_range(0, 5);
				for (k = 0; k < len; k++) begin
					b = 8'($urandom_range(0, 255));
					send_request(OP_RX, b);
					if (b == BYTE_IAC) begin
						b = 8'($urandom_range(0, 254));
						if (b == BYTE_SE)
							b = BYTE_IAC;
						send_request(OP_RX, b);
					end
				end
				send_request(OP_RX, BYTE_IAC);
				send_request(OP_RX, BYTE_SE);
			end else if (kind < 75) begin
				send_request(OP_RX, BYTE_IAC);
				send_request(OP_RX, 8'($urandom_range(0, 255)));
			end else if (kind < 93) begin
				send_request(OP_TX, pick_tx_char());
			end else begin
				send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Receiver stalls for a long stretch while the sender keeps offering
	// double-result transmits, so the result buffer fills and in_ready drops.
	task automatic test_output_backpressure();
		int unsigned k;
		no_idle  = 1'b1;
		hold_cnt = 400;
		for (k = 0; k < 40; k++)
			send_request(OP_TX, (k % 2 == 0) ? BYTE_IAC : BYTE_CR);
		no_idle = 1'b0;
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		test_random_traffic(200);
		no_idle = 1'b0;
	endtask

	// receiver: long hold-off, free-running stretches, random stalls
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_cnt != 0) begin
				out_ready <= 1'b0;
				hold_cnt--;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < 30)
					stall_left = pick_gap();
			end
		end
	end

	// monitor: predict on each accepted request, check each accepted result
	initial begin
		out_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (in_valid && in_ready === 1'b1) begin
					predict_filter(in_data);
					requests_accepted++;
				end
				if (out_valid === 1'b1 && out_ready) begin
					results_seen++;
					if (expected_results.size() == 0) begin
						$error("unexpected result: direction %0d out_byte %0h last %0d",
							out_data.direction, out_data.out_byte, out_data.last);
						errors++;
					end else begin
						want = expected_results.pop_front();
						if (out_data.direction !== want.direction) begin
							$error("direction: expected %0d, actual %0d",
								want.direction, out_data.direction);
							errors++;
						end
						if (out_data.out_byte !== want.out_byte) begin
							$error("out_byte: expected %0h, actual %0h",
								want.out_byte, out_data.out_byte);
							errors++;
						end
						if (out_data.last !== want.last) begin
							$error("last: expected %0d, actual %0d",
								want.last, out_data.last);
							errors++;
						end
					end
				end
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycles, expected_results.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		in_data           = '0;
		rx_state          = ST_START;
		cr_seen           = 1'b0;
		errors            = 0;
		requests_sent     = 0;
		requests_accepted = 0;
		results_seen      = 0;
		hold_cnt          = 0;
		no_idle           = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_tx_escaping();
		test_iac_commands();
		test_option_negotiation();
		test_subnegotiation();
		test_cr_nul();
		test_output_backpressure();
		test_random_traffic(RANDOM_ITEMS / 2);
		test_back_to_back();
		test_random_traffic(RANDOM_ITEMS / 2);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_results.size() != 0)
			errors++;
		$display("%0d requests in, %0d results out, %0d mismatches", requests_accepted,
			results_seen, errors);
		$display("covered TX escaping, IAC commands, option and SB skipping, CR NUL, stalls");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
